// ----- src/lpht_pkg.sv -----
// Package with the transaction types, entry layout and codes of the linear probe hash table.
`default_nettype none
package lpht_pkg;

    localparam int KEY_W = 17;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_SEARCH = 2'd2;

    localparam logic [2:0] STAT_INSERTED  = 3'd0;
    localparam logic [2:0] STAT_DUPLICATE = 3'd1;
    localparam logic [2:0] STAT_FULL      = 3'd2;
    localparam logic [2:0] STAT_REMOVED   = 3'd3;
    localparam logic [2:0] STAT_FOUND     = 3'd4;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd5;

    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_USED    = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    typedef struct packed {
        logic [1:0]       func;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] record_position;
    } t_hash_req;

    typedef struct packed {
        logic [2:0]       status;
        logic [3:0]       slot;
        logic [KEY_W-1:0] found_position;
        logic [3:0]       probe_count;
    } t_hash_rsp;

    typedef struct packed {
        logic [1:0]       mark;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] pos;
    } t_entry;

endpackage
`default_nettype wire

// ----- src/lpht_mod.sv -----
// Unit that reduces a key modulo the table size by reciprocal multiplication.
`default_nettype none
module lpht_mod #(
    parameter int DIVISOR = 13
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [lpht_pkg::KEY_W-1:0]   i_key,
    output logic                              o_done,
    output logic [$clog2(DIVISOR)-1:0]        o_rem
);
    import lpht_pkg::*;

    localparam int IW = $clog2(DIVISOR);
    localparam int SH = KEY_W + IW;
    localparam int PW = 2 * KEY_W + 1;
    localparam logic [KEY_W:0] RECIP =
        (KEY_W+1)'(((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR));

    logic             r_stage;
    logic             r_done;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_quot;
    logic [IW-1:0]    r_rem;
    logic [PW-1:0]    w_prod;
    logic [PW-1:0]    w_prod_shr;
    logic [KEY_W-1:0] w_back;
    logic [KEY_W-1:0] w_diff;

    // The quotient comes from the scaled reciprocal, the remainder from one multiply back.
    assign w_prod     = PW'(i_key) * PW'(RECIP);
    assign w_prod_shr = w_prod >> SH;
    assign w_back     = r_quot * KEY_W'(DIVISOR);
    assign w_diff     = r_key - w_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= i_start;
            r_done  <= r_stage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key  <= i_key;
            r_quot <= w_prod_shr[KEY_W-1:0];
        end
        if (r_stage) begin
            r_rem <= w_diff[IW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ----- src/linear_probe_hash_table.sv -----
// Top level of the open-addressing hash table with linear probing over one slot memory.
`default_nettype none
// Usage: raise start with a request on i_req while busy is low; the transaction is taken at
// that clock edge and busy rises at once. The request is an insert, remove or search of a
// 17-bit key. The home slot is the key modulo TABLE_SLOTS, found by a reciprocal
// multiplication. The slot memory is then swept from home, one read per cycle, for
// TABLE_SLOTS reads; each read is registered before it is compared, and a finishing
// state decides the outcome and, for an insert or remove that succeeds, writes the slot.
// o_valid pulses for exactly one cycle with the result on o_result, and busy falls in
// that same cycle so a new transaction can be taken at its end. One transaction is in
// flight at a time.
// The receiver cannot stall: a result is shown once and must be taken in that cycle.
// After reset the memory is cleared one slot per cycle, all TABLE_SLOTS slots, with busy high.
module linear_probe_hash_table #(
    parameter int TABLE_SLOTS = 13
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire lpht_pkg::t_hash_req  i_req,
    output logic                      busy,
    output logic                      o_valid,
    output lpht_pkg::t_hash_rsp       o_result
);
    import lpht_pkg::*;

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int XW = IW + 4;
    localparam logic [IW-1:0] LAST_SLOT   = IW'(TABLE_SLOTS - 1);
    localparam logic [3:0]    FULL_PROBES = 4'(TABLE_SLOTS);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_HASH   = 3'd2;
    localparam logic [2:0] ST_SWEEP  = 3'd3;
    localparam logic [2:0] ST_LAST   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    t_entry mem [TABLE_SLOTS];

    logic [2:0]       r_state;
    t_hash_req        r_req;
    logic [IW-1:0]    r_addr;
    logic [IW-1:0]    r_step;
    logic             r_rd_vld;
    logic [IW-1:0]    r_rd_slot;
    logic [IW-1:0]    r_rd_step;
    t_entry           r_rd_data;
    logic             r_hit;
    logic [IW-1:0]    r_hit_slot;
    logic [IW-1:0]    r_hit_step;
    logic [KEY_W-1:0] r_hit_pos;
    logic             r_free;
    logic [IW-1:0]    r_free_slot;
    logic [IW-1:0]    r_free_step;
    logic             r_valid;
    t_hash_rsp        r_result;

    logic          w_accept;
    logic          w_mod_done;
    logic [IW-1:0] w_home;
    logic [IW-1:0] w_addr_next;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    t_entry        w_wdata;
    t_hash_rsp     n_result;
    logic [XW-1:0] w_hit_slot_x;
    logic [XW-1:0] w_hit_step_x;
    logic [XW-1:0] w_free_slot_x;
    logic [XW-1:0] w_free_step_x;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    lpht_mod #(
        .DIVISOR (TABLE_SLOTS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_key   (i_req.key),
        .o_done  (w_mod_done),
        .o_rem   (w_home)
    );

    assign w_addr_next   = (r_addr == LAST_SLOT) ? '0 : r_addr + 1'b1;
    assign w_hit_slot_x  = XW'(r_hit_slot);
    assign w_hit_step_x  = XW'(r_hit_step);
    assign w_free_slot_x = XW'(r_free_slot);
    assign w_free_step_x = XW'(r_free_step);

    always_comb begin
        w_we     = 1'b0;
        w_waddr  = r_addr;
        w_wdata  = '{mark: MARK_EMPTY, key: '0, pos: '0};
        n_result = '{status: STAT_NOT_FOUND, slot: 4'd0, found_position: '0, probe_count: 4'd0};
        if (r_state == ST_CLEAR) begin
            w_we = 1'b1;
        end else if (r_state == ST_FINISH) begin
            case (r_req.func)
                FUNC_INSERT: begin
                    if (r_hit) begin
                        n_result.status = STAT_DUPLICATE;
                        n_result.slot   = w_hit_slot_x[3:0];
                    end else if (r_free) begin
                        w_we                 = 1'b1;
                        w_waddr              = r_free_slot;
                        w_wdata              = '{mark: MARK_USED, key: r_req.key,
                                                 pos: r_req.record_position};
                        n_result.status      = STAT_INSERTED;
                        n_result.slot        = w_free_slot_x[3:0];
                        n_result.probe_count = w_free_step_x[3:0];
                    end else begin
                        n_result.status      = STAT_FULL;
                        n_result.probe_count = FULL_PROBES;
                    end
                end
                FUNC_REMOVE, FUNC_SEARCH: begin
                    if (r_hit) begin
                        n_result.slot        = w_hit_slot_x[3:0];
                        n_result.probe_count = w_hit_step_x[3:0];
                        if (r_req.func == FUNC_REMOVE) begin
                            w_we            = 1'b1;
                            w_waddr         = r_hit_slot;
                            w_wdata         = '{mark: MARK_DELETED, key: '0, pos: '0};
                            n_result.status = STAT_REMOVED;
                        end else begin
                            n_result.status         = STAT_FOUND;
                            n_result.found_position = r_hit_pos;
                        end
                    end else begin
                        n_result.probe_count = FULL_PROBES;
                    end
                end
                default: begin
                    n_result.status = STAT_NOT_FOUND;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (r_state == ST_SWEEP) begin
            r_rd_data <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= (r_state == ST_FINISH);
            if (r_rd_vld) begin
                if (!r_hit && r_rd_data.mark == MARK_USED && r_rd_data.key == r_req.key) begin
                    r_hit      <= 1'b1;
                    r_hit_slot <= r_rd_slot;
                    r_hit_step <= r_rd_step;
                    r_hit_pos  <= r_rd_data.pos;
                end
                if (!r_free && r_rd_data.mark != MARK_USED) begin
                    r_free      <= 1'b1;
                    r_free_slot <= r_rd_slot;
                    r_free_step <= r_rd_step;
                end
            end
            case (r_state)
                ST_CLEAR: begin
                    r_addr <= w_addr_next;
                    if (r_addr == LAST_SLOT) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_req   <= i_req;
                        r_state <= ST_HASH;
                    end
                end
                ST_HASH: begin
                    if (w_mod_done) begin
                        r_addr  <= w_home;
                        r_step  <= '0;
                        r_hit   <= 1'b0;
                        r_free  <= 1'b0;
                        r_state <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    r_rd_vld  <= 1'b1;
                    r_rd_slot <= r_addr;
                    r_rd_step <= r_step;
                    r_addr    <= w_addr_next;
                    r_step    <= r_step + 1'b1;
                    if (r_step == LAST_SLOT) begin
                        r_state <= ST_LAST;
                    end
                end
                ST_LAST: begin
                    r_rd_vld <= 1'b0;
                    r_state  <= ST_FINISH;
                end
                ST_FINISH: begin
                    r_result <= n_result;
                    r_state  <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire
